>>> hw/rtl/dlsd_pkg.sv
// Shared constants and types for the dark line span detector.
`default_nettype none

package dlsd_pkg;

   // Line geometry
   localparam int LINE_PIXELS = 640;
   localparam int ADDR_W      = $clog2(LINE_PIXELS);

   // Pixel and result field widths
   localparam int PIXEL_W = 8;
   localparam int RED_W   = 5;
   localparam int RED_LSB = PIXEL_W - RED_W;
   localparam int PCT_W   = 7;
   localparam int IDX_W   = 10;
   localparam int THR_W   = 8;
   localparam int AVG_W   = 8;
   localparam int FLAG_W  = 2;

   // Packed result data: start, end, width, threshold, padded to bytes
   localparam int RSP_BITS   = 3 * IDX_W + THR_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Running sum never wraps: largest masked pixel is 248
   localparam int MAX_RED = 248;
   localparam int SUM_W   = $clog2(LINE_PIXELS * MAX_RED + 1);

   // Line average by reciprocal multiply, then one correction step
   localparam int DIV_SHIFT = SUM_W + 10;
   localparam int RECIP_W   = DIV_SHIFT + 1 - $clog2(LINE_PIXELS);
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'((64'(1) << DIV_SHIFT) / LINE_PIXELS);
   localparam int PROD1_W = SUM_W + RECIP_W;

   // Percent scaling: divide by 100 through a rounded-up reciprocal
   localparam int PCT_FULL  = 100;
   localparam int PROD2_W   = AVG_W + PCT_W;
   localparam int PCT_SHIFT = 19;
   localparam int PRECIP_W  = 13;
   localparam logic [PRECIP_W-1:0] PCT_RECIP =
      PRECIP_W'(((64'(1) << PCT_SHIFT) + PCT_FULL - 1) / PCT_FULL);
   localparam int PROD3_W = PROD2_W + PRECIP_W;

   localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(42);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_FILL,
      ST_DIV_MUL,
      ST_DIV_FIX,
      ST_THR_MUL,
      ST_THR_DIV,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage : dlsd_pkg

`default_nettype wire

>>> hw/rtl/dark_line_span_detector_core.sv
// Top level of the dark line span detector: line buffer, threshold and scan.
`default_nettype none

// Takes one camera line of LINE_PIXELS pixel high bytes (one item each) and
// keeps the red bits of each. After the last pixel of a line the block
// forms the line average and the dark threshold (average scaled down by the
// drop percent, saturated at 100), then reads the line back from its buffer
// and reports the first pixel below the threshold and the first later pixel
// above it. Pixels are taken one per cycle while a line fills; after the
// line, req_tready stays low through four arithmetic steps, one buffer
// read per pixel through the single memory port, one drain step and one
// load of the result register. A result waiting on rsp_tready does not
// block filling of the next line, but that line's last step waits, with
// req_tready low, until the waiting result has been taken. The drop
// percent may be written only while idle.
module dark_line_span_detector_core (
   input  wire                             clock,
   input  wire                             reset,
   // req_tdata: pixel_byte[7:0]
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire [dlsd_pkg::PIXEL_W-1:0]     req_tdata,
   // rsp_tdata: start_index[9:0], end_index[19:10], span_width[29:20],
   //            line_threshold[37:30], zero padding
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [dlsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: start_found[0], end_found[1]
   output logic [dlsd_pkg::FLAG_W-1:0]     rsp_tuser,
   // threshold_drop_percent
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [dlsd_pkg::PCT_W-1:0]       csr_data
);
   import dlsd_pkg::*;

   // Line buffer
   logic [RED_W-1:0] pixel_mem [LINE_PIXELS];

   state_type state_ff, state_in;

   logic [PCT_W-1:0]    pct_ff, pct_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PROD1_W-1:0]  prod1_ff, prod1_in;
   logic [AVG_W-1:0]    avg_ff, avg_in;
   logic [PROD2_W-1:0]  prod2_ff, prod2_in;
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic [RED_W-1:0]    rd_data_ff;
   logic [ADDR_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                start_found_ff, start_found_in;
   logic                end_found_ff, end_found_in;
   logic [ADDR_W-1:0]   start_idx_ff, start_idx_in;
   logic [ADDR_W-1:0]   end_idx_ff, end_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [FLAG_W-1:0]   rsp_user_ff, rsp_user_in;

   // Control strobes from the sequencer
   logic fill_en, scan_issue, clear_sum, clear_scan, load_rsp;

   logic                fill_accept;
   logic                addr_last;
   logic [RED_W-1:0]    red_bits;
   logic [AVG_W-1:0]    q_est;
   logic [SUM_W-1:0]    q_times_len;
   logic [SUM_W-1:0]    div_rem;
   logic [PCT_W-1:0]    pct_sat;
   logic [PROD3_W-1:0]  prod3;
   logic [PIXEL_W-1:0]  rd_pixel;
   logic [IDX_W-1:0]    start_out, end_out, span_out;

   assign fill_accept = fill_en && req_tvalid;
   assign addr_last   = (addr_ff == ADDR_W'(LINE_PIXELS - 1));
   assign red_bits    = req_tdata[PIXEL_W-1:RED_LSB];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL:    if (fill_accept && addr_last) state_in = ST_DIV_MUL;
         ST_DIV_MUL: state_in = ST_DIV_FIX;
         ST_DIV_FIX: state_in = ST_THR_MUL;
         ST_THR_MUL: state_in = ST_THR_DIV;
         ST_THR_DIV: state_in = ST_SCAN;
         ST_SCAN:    if (addr_last) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_EMIT;
         ST_EMIT:    if (!rsp_valid_ff) state_in = ST_FILL;
         default:    state_in = ST_FILL;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      fill_en    = 1'b0;
      scan_issue = 1'b0;
      clear_sum  = 1'b0;
      clear_scan = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_FILL:    fill_en    = 1'b1;
         ST_THR_MUL: clear_sum  = 1'b1;
         ST_THR_DIV: clear_scan = 1'b1;
         ST_SCAN:    scan_issue = 1'b1;
         ST_EMIT:    load_rsp   = !rsp_valid_ff;
         default:    ;
      endcase
   end

   assign req_tready = fill_en;
   assign csr_ready  = 1'b1;

   // Config register
   assign pct_in = (csr_valid && csr_ready) ? csr_data : pct_ff;

   // Shared fill / scan address, wraps at the line end
   always_comb begin
      addr_in = addr_ff;
      if (fill_accept || scan_issue) begin
         addr_in = addr_last ? '0 : addr_ff + ADDR_W'(1);
      end
   end

   // Running sum of masked pixels
   always_comb begin
      sum_in = sum_ff;
      if (fill_accept) begin
         sum_in = sum_ff + SUM_W'({red_bits, {RED_LSB{1'b0}}});
      end else if (clear_sum) begin
         sum_in = '0;
      end
   end

   // Average: estimate by reciprocal, low by at most one, then correct
   assign prod1_in    = (state_ff == ST_DIV_MUL) ? PROD1_W'(sum_ff) * PROD1_W'(DIV_RECIP)
                                                 : prod1_ff;
   assign q_est       = prod1_ff[DIV_SHIFT +: AVG_W];
   assign q_times_len = SUM_W'(q_est) * SUM_W'(LINE_PIXELS);
   assign div_rem     = sum_ff - q_times_len;
   always_comb begin
      avg_in = avg_ff;
      if (state_ff == ST_DIV_FIX) begin
         avg_in = (div_rem >= SUM_W'(LINE_PIXELS)) ? q_est + AVG_W'(1) : q_est;
      end
   end

   // Threshold: average times (100 - percent), divided by 100
   assign pct_sat  = (pct_ff > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_ff;
   assign prod2_in = (state_ff == ST_THR_MUL)
                     ? PROD2_W'(avg_ff) * PROD2_W'(PCT_W'(PCT_FULL) - pct_sat)
                     : prod2_ff;
   assign prod3    = PROD3_W'(prod2_ff) * PROD3_W'(PCT_RECIP);
   assign thr_in   = (state_ff == ST_THR_DIV) ? prod3[PCT_SHIFT +: THR_W] : thr_ff;

   // Read pipeline tag
   assign rd_valid_in = scan_issue;
   assign rd_idx_in   = scan_issue ? addr_ff : rd_idx_ff;
   assign rd_pixel    = {rd_data_ff, {RED_LSB{1'b0}}};

   // Scan compare on each buffer word as it returns
   always_comb begin
      start_found_in = start_found_ff;
      end_found_in   = end_found_ff;
      start_idx_in   = start_idx_ff;
      end_idx_in     = end_idx_ff;
      if (clear_scan) begin
         start_found_in = 1'b0;
         end_found_in   = 1'b0;
         start_idx_in   = '0;
         end_idx_in     = '0;
      end else if (rd_valid_ff) begin
         if (!start_found_ff) begin
            if (rd_pixel < thr_ff) begin
               start_found_in = 1'b1;
               start_idx_in   = rd_idx_ff;
            end
         end else if (!end_found_ff && (rd_pixel > thr_ff)) begin
            end_found_in = 1'b1;
            end_idx_in   = rd_idx_ff;
         end
      end
   end

   // Result register
   assign start_out = IDX_W'(start_idx_ff);
   assign end_out   = IDX_W'(end_idx_ff);
   assign span_out  = (start_found_ff && end_found_ff)
                      ? IDX_W'(end_idx_ff - start_idx_ff) : '0;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({thr_ff, span_out, end_out, start_out});
         rsp_user_in  = {end_found_ff, start_found_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Line buffer access: writes while filling, reads while scanning
   always_ff @(posedge clock) begin
      if (fill_accept) begin
         pixel_mem[addr_ff] <= red_bits;
      end
      if (scan_issue) begin
         rd_data_ff <= pixel_mem[addr_ff];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         pct_ff       <= PCT_RESET;
         addr_ff      <= '0;
         sum_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pct_ff       <= pct_in;
         addr_ff      <= addr_in;
         sum_ff       <= sum_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod1_ff       <= prod1_in;
      avg_ff         <= avg_in;
      prod2_ff       <= prod2_in;
      thr_ff         <= thr_in;
      rd_idx_ff      <= rd_idx_in;
      start_found_ff <= start_found_in;
      end_found_ff   <= end_found_in;
      start_idx_ff   <= start_idx_in;
      end_idx_ff     <= end_idx_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

endmodule : dark_line_span_detector_core

`default_nettype wire

>>> hw/rtl/dlsd_checker.sv
// Port-level checks for the dark line span detector, bound to the top level.
`default_nettype none

module dlsd_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [dlsd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire [dlsd_pkg::FLAG_W-1:0]      rsp_tuser
);
   import dlsd_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No start means zero start index and zero width
   a_no_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[9:0] == 10'd0 && rsp_tdata[29:20] == 10'd0)
      else $error("start index or width set without a start");

   // No end means zero end index and zero width
   a_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[19:10] == 10'd0 && rsp_tdata[29:20] == 10'd0)
      else $error("end index or width set without an end");

   // Width is end minus start when both are found
   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tuser[1]
      |-> rsp_tdata[29:20] == 10'(rsp_tdata[19:10] - rsp_tdata[9:0]))
      else $error("span width does not match indices");

   // An end is only ever reported with a start
   a_end_needs_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("end found without start");

endmodule : dlsd_checker

bind dark_line_span_detector_core dlsd_checker u_dlsd_checker (.*);

`default_nettype wire
